FILE: rtl/knn_pkg.sv
// shared types and constants for the knn top-k search core
package knn_pkg;

   localparam int MAX_DIMENSION_DEF = 128;
   localparam int MAX_NEIGHBORS_DEF = 16;

   localparam int ELEM_W  = 16;
   localparam int ID_W    = 31;
   localparam int DIST_W  = 39;
   localparam int SQ_W    = 32;
   localparam int DIM_W   = 8;
   localparam int NBR_W   = 5;
   localparam int RANK_W  = 4;
   localparam int CSR_W   = 31;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam logic KIND_QUERY = 1'b0;
   localparam logic KIND_BASE  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_ID   = 2'd0,
      CSR_DIMENSION = 2'd1,
      CSR_NEIGHBORS = 2'd2
   } knn_csr_type;

   // finished vector (or end of search) handed to the top-k list
   typedef struct packed {
      logic              valid;
      logic              insert;
      logic              last;
      logic [DIST_W-1:0] dist_sq;
      logic [ID_W-1:0]   id;
   } knn_pair_type;

endpackage

FILE: rtl/knn_ram.sv
// generic single-write, single-read ram with registered read data
module knn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/knn_dist.sv
// element position, query store and squared distance accumulation
module knn_dist
   import knn_pkg::*;
#(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic                     in_kind,
   input  logic signed [ELEM_W-1:0] in_element,
   input  logic                     in_last,
   input  logic [ID_W-1:0]          base_id,
   input  logic [DIM_W-1:0]         dimension,
   output knn_pair_type             pair
);

   localparam int PW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;

   logic            accept;
   logic [PW-1:0]   dim_m1;
   logic [PW-1:0]   pos_ff, pos_in, pos_cur;
   logic            vec_end;
   logic [ELEM_W-1:0] query_rd;

   // stage 1
   logic              s1_valid_ff, s1_kind_ff, s1_last_ff, s1_end_ff;
   logic [ELEM_W-1:0] s1_elem_ff;
   logic signed [ELEM_W:0]       diff;
   logic signed [2*ELEM_W+1:0]   prod;

   // stage 2
   logic              s2_valid_ff, s2_kind_ff, s2_last_ff, s2_end_ff;
   logic [SQ_W-1:0]   s2_sq_ff;
   logic [DIST_W-1:0] acc_ff, acc_in, acc_sat;
   logic [DIST_W:0]   acc_sum;
   logic [ID_W-1:0]   vcount_ff, vcount_in;
   logic              s2_base;
   knn_pair_type      pair_ff, pair_in;

   assign accept = in_valid && advance;

   always_comb begin
      if (dimension == '0) begin
         dim_m1 = '0;
      end else if (32'(dimension) > 32'(MAX_DIMENSION)) begin
         dim_m1 = PW'(MAX_DIMENSION - 1);
      end else begin
         dim_m1 = PW'(dimension - DIM_W'(1));
      end
   end

   assign pos_cur = (pos_ff > dim_m1) ? dim_m1 : pos_ff;
   assign vec_end = (pos_cur == dim_m1);

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if ((in_kind == KIND_BASE && in_last) || vec_end) begin
            pos_in = '0;
         end else begin
            pos_in = pos_cur + PW'(1);
         end
      end
   end

   knn_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (MAX_DIMENSION)
   ) u_query_ram (
      .clock   (clock),
      .wr_en   (accept && in_kind == KIND_QUERY),
      .wr_addr (pos_cur),
      .wr_data (in_element),
      .rd_en   (accept && in_kind == KIND_BASE),
      .rd_addr (pos_cur),
      .rd_data (query_rd)
   );

   // stage 1: difference and square
   assign diff = $signed({query_rd[ELEM_W-1], query_rd})
               - $signed({s1_elem_ff[ELEM_W-1], s1_elem_ff});
   assign prod = diff * diff;

   // stage 2: saturating accumulate, id assignment
   assign s2_base = (s2_kind_ff == KIND_BASE);
   assign acc_sum = {1'b0, acc_ff} + (DIST_W + 1)'(s2_sq_ff);
   assign acc_sat = (acc_sum > {1'b0, DIST_MAX}) ? DIST_MAX : acc_sum[DIST_W-1:0];

   always_comb begin
      acc_in    = acc_ff;
      vcount_in = vcount_ff;
      pair_in   = pair_ff;
      pair_in.valid = 1'b0;
      if (s2_valid_ff) begin
         if (!s2_base) begin
            acc_in = '0;
         end else begin
            acc_in = (s2_end_ff || s2_last_ff) ? '0 : acc_sat;
            if (s2_end_ff) begin
               vcount_in = vcount_ff + ID_W'(1);
            end
            if (s2_last_ff) begin
               vcount_in = '0;
            end
            pair_in.valid   = s2_end_ff || s2_last_ff;
            pair_in.insert  = s2_end_ff;
            pair_in.last    = s2_last_ff;
            pair_in.dist_sq = acc_sat;
            pair_in.id      = base_id + vcount_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         acc_ff      <= '0;
         vcount_ff   <= '0;
         pair_ff     <= '0;
      end else if (advance) begin
         pos_ff      <= pos_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         acc_ff      <= acc_in;
         vcount_ff   <= vcount_in;
         pair_ff     <= pair_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff <= in_kind;
         s1_last_ff <= in_last;
         s1_end_ff  <= vec_end;
         s1_elem_ff <= in_element;
         s2_kind_ff <= s1_kind_ff;
         s2_last_ff <= s1_last_ff;
         s2_end_ff  <= s1_end_ff;
         s2_sq_ff   <= prod[SQ_W-1:0];
      end
   end

   assign pair = pair_ff;

   a_last_clears_pos: assert property (@(posedge clock) disable iff (reset)
      accept && in_kind == KIND_BASE && in_last |=> pos_ff == '0)
      else $error("position not cleared after end of search");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> pos_ff <= PW'(MAX_DIMENSION - 1))
      else $error("element position beyond query store");

endmodule

FILE: rtl/knn_topk.sv
// sorted top-k list with parallel insert and result drain buffer
module knn_topk
   import knn_pkg::*;
#(
   parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  knn_pair_type        pair,
   input  logic [NBR_W-1:0]    neighbors_wanted,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [RANK_W-1:0]   rsp_rank,
   output logic [ID_W-1:0]     rsp_neighbor_id,
   output logic [DIST_W-1:0]   rsp_distance_sq,
   output logic                rsp_last
);

   localparam int N  = MAX_NEIGHBORS;
   localparam int KW = $clog2(MAX_NEIGHBORS + 1);
   localparam int RW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

   logic [KW-1:0]     k_eff, n_cur, ins_pos, new_cnt;
   logic [KW-1:0]     cnt_ff, cnt_in;
   logic [DIST_W-1:0] dist_ff [N];
   logic [ID_W-1:0]   id_ff   [N];
   logic [DIST_W-1:0] new_dist [N];
   logic [ID_W-1:0]   new_id   [N];
   logic [N-1:0]      ge;
   logic              ins_ok, take, load;

   logic [KW-1:0]     out_cnt_ff, out_cnt_in;
   logic [RW-1:0]     rank_ff, rank_in;
   logic [DIST_W-1:0] out_dist_ff [N];
   logic [ID_W-1:0]   out_id_ff   [N];
   logic              out_fire;

   function automatic logic key_less(input logic [DIST_W-1:0] d1, input logic [ID_W-1:0] i1,
                                     input logic [DIST_W-1:0] d2, input logic [ID_W-1:0] i2);
      return (d1 < d2) || (d1 == d2 && i1 < i2);
   endfunction

   always_comb begin
      if (neighbors_wanted == '0) begin
         k_eff = KW'(1);
      end else if (32'(neighbors_wanted) > 32'(N)) begin
         k_eff = KW'(N);
      end else begin
         k_eff = KW'(neighbors_wanted);
      end
   end

   assign n_cur = (cnt_ff > k_eff) ? k_eff : cnt_ff;

   // entries that stay ahead of the new pair form a prefix of the sorted list
   always_comb begin
      for (int i = 0; i < N; i++) begin
         ge[i] = (KW'(i) < n_cur) && !key_less(pair.dist_sq, pair.id, dist_ff[i], id_ff[i]);
      end
   end

   assign ins_pos = KW'($countones(ge));
   assign ins_ok  = pair.insert && (ins_pos < k_eff);

   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (!ins_ok || ge[i]) begin
            new_dist[i] = dist_ff[i];
            new_id[i]   = id_ff[i];
         end else if (i == 0 || ge[(i > 0) ? i - 1 : 0]) begin
            new_dist[i] = pair.dist_sq;
            new_id[i]   = pair.id;
         end else begin
            new_dist[i] = dist_ff[(i > 0) ? i - 1 : 0];
            new_id[i]   = id_ff[(i > 0) ? i - 1 : 0];
         end
      end
   end

   always_comb begin
      if (ins_ok) begin
         new_cnt = (n_cur == k_eff) ? k_eff : n_cur + KW'(1);
      end else begin
         new_cnt = n_cur;
      end
   end

   // hold the pipeline while a finished list waits for the previous one to drain
   assign advance  = !(pair.valid && pair.last && out_cnt_ff != '0);
   assign take     = pair.valid && advance;
   assign load     = take && pair.last;
   assign out_fire = rsp_valid && rsp_ready;

   always_comb begin
      cnt_in     = cnt_ff;
      out_cnt_in = out_cnt_ff;
      rank_in    = rank_ff;
      if (take) begin
         cnt_in = pair.last ? '0 : new_cnt;
      end
      if (load) begin
         out_cnt_in = new_cnt;
         rank_in    = '0;
      end else if (out_fire) begin
         out_cnt_in = out_cnt_ff - KW'(1);
         rank_in    = rank_ff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         out_cnt_ff <= '0;
         rank_ff    <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         out_cnt_ff <= out_cnt_in;
         rank_ff    <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !pair.last) begin
         dist_ff <= new_dist;
         id_ff   <= new_id;
      end
      if (load) begin
         out_dist_ff <= new_dist;
         out_id_ff   <= new_id;
      end else if (out_fire) begin
         for (int i = 0; i < N - 1; i++) begin
            out_dist_ff[i] <= out_dist_ff[i + 1];
            out_id_ff[i]   <= out_id_ff[i + 1];
         end
      end
   end

   assign rsp_valid       = (out_cnt_ff != '0);
   assign rsp_last        = (out_cnt_ff == KW'(1));
   assign rsp_rank        = RANK_W'(rank_ff);
   assign rsp_neighbor_id = out_id_ff[0];
   assign rsp_distance_sq = out_dist_ff[0];

   a_out_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= KW'(N))
      else $error("drain count exceeds list size");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      out_fire && !rsp_last |=> rsp_valid)
      else $error("result list interrupted");

   a_end_of_list: assert property (@(posedge clock) disable iff (reset)
      out_fire && rsp_last |=> !rsp_valid)
      else $error("result after end of list");

   a_list_cleared: assert property (@(posedge clock) disable iff (reset)
      load |=> cnt_ff == '0)
      else $error("top-k list not cleared after emission");

endmodule

FILE: rtl/knn_top_k_search_core.sv
// top level of the brute-force knn top-k search core
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   req_kind, req_element, req_last_in_base
//   rsp       out        rsp_valid / rsp_ready   rsp_rank, rsp_neighbor_id,
//                                                rsp_distance_sq, rsp_last
//   csr       in         csr_we                  csr_index, csr_wdata
//
// one element is taken per cycle while req_ready is high; the path is query ram read, square, accumulate, list insert
// an end of search's list passes stage 1, stage 2, pair and drain registers; one result a cycle with rsp_ready high
// intake pauses only while a finished list reaches the list stage and the previous list drains
// reset is synchronous; the query ram is not cleared, all search state is
module knn_top_k_search_core
   import knn_pkg::*;
#(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
   parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic signed [ELEM_W-1:0] req_element,
   input  logic                     req_last_in_base,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [RANK_W-1:0]        rsp_rank,
   output logic [ID_W-1:0]          rsp_neighbor_id,
   output logic [DIST_W-1:0]        rsp_distance_sq,
   output logic                     rsp_last,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   logic [ID_W-1:0]  base_id_ff;
   logic [DIM_W-1:0] dimension_ff;
   logic [NBR_W-1:0] neighbors_ff;
   logic             advance;
   knn_pair_type     pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff   <= '0;
         dimension_ff <= DIM_W'(128);
         neighbors_ff <= NBR_W'(10);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_ID:   base_id_ff   <= csr_wdata[ID_W-1:0];
            CSR_DIMENSION: dimension_ff <= csr_wdata[DIM_W-1:0];
            CSR_NEIGHBORS: neighbors_ff <= csr_wdata[NBR_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = advance;

   knn_dist #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .in_kind    (req_kind),
      .in_element (req_element),
      .in_last    (req_last_in_base),
      .base_id    (base_id_ff),
      .dimension  (dimension_ff),
      .pair       (pair)
   );

   knn_topk #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_topk (
      .clock            (clock),
      .reset            (reset),
      .pair             (pair),
      .neighbors_wanted (neighbors_ff),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rank         (rsp_rank),
      .rsp_neighbor_id  (rsp_neighbor_id),
      .rsp_distance_sq  (rsp_distance_sq),
      .rsp_last         (rsp_last)
   );

endmodule
